[design/resp_request_stream_parser_top_defines.svh]
// Assertion macros shared by the request stream parser RTL.
`ifndef RESP_REQUEST_STREAM_PARSER_TOP_DEFINES_SVH
`define RESP_REQUEST_STREAM_PARSER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge, switched off while reset is held.
`define RRSP_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define RRSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RRSP_ASSERT_RST(label, clk, rst_n, prop, msg)
`define RRSP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[design/rrsp_pkg.sv]
// Constants and types of the request stream parser.
`timescale 1ns / 1ps
`default_nettype none

package rrsp_pkg;

    localparam int MAX_ARGS    = 64;
    localparam int LENGTH_BITS = 32;
    localparam int NUM_W       = LENGTH_BITS + 1;
    localparam int ARG_W       = $clog2(MAX_ARGS + 1);

    localparam logic [NUM_W-1:0] NUM_SAT  = NUM_W'(1) << LENGTH_BITS;
    localparam logic [NUM_W-1:0] ARGS_LIM = NUM_W'(MAX_ARGS);

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_NUM   = 3'd1;
    localparam logic [2:0] ERR_BELOW_M1  = 3'd2;
    localparam logic [2:0] ERR_NO_DOLLAR = 3'd3;
    localparam logic [2:0] ERR_NO_CRLF   = 3'd4;
    localparam logic [2:0] ERR_MANY_ARGS = 3'd5;

    typedef struct packed {
        logic [7:0] arg_byte;
        logic       byte_valid;
        logic [5:0] arg_index;
        logic       arg_done;
        logic       arg_null;
        logic       cmd_done;
        logic [6:0] arg_count;
        logic [2:0] error_code;
    } t_result;

endpackage

`default_nettype wire

[design/resp_request_stream_parser_top.sv]
// Request stream parser: one request byte in, at most one argument result out.
// The block takes one request byte per clock cycle for as long as the result side keeps up.
// Each accepted byte is held in an input register and, once a queue entry is free, goes
// through the whole parser state update in a single pass; any result is registered into a
// two-entry output queue and is offered on the output from there, oldest result first.
// The queue
// lets the input keep flowing while one result waits; input stalls only when both
// queue entries are occupied. Once a malformed request has been reported, the error
// result is the last one given and further bytes are consumed silently until reset.
`timescale 1ns / 1ps
`default_nettype none
`include "resp_request_stream_parser_top_defines.svh"

module resp_request_stream_parser_top
    import rrsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] arg_byte, [13:8] arg_index, [20:14] arg_count, [23:21] error_code
    output logic [23:0]      m_axis_tdata,
    // [0] byte_valid, [1] arg_done, [2] arg_null
    output logic [2:0]       m_axis_tuser,
    output logic             m_axis_tlast    // cmd_done
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_IDLE_CR,
        PH_INLINE,
        PH_INLINE_CR,
        PH_COUNT,
        PH_COUNT_CR,
        PH_DOLLAR,
        PH_LEN,
        PH_LEN_CR,
        PH_PAYLOAD,
        PH_PAY_CR,
        PH_PAY_LF
    } t_phase;

    // Input register
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;

    // Parser state
    t_phase                 r_phase,      n_phase;
    logic [NUM_W-1:0]       r_num,        n_num;
    logic                   r_neg,        n_neg;
    logic                   r_dig_seen,   n_dig_seen;
    logic                   r_dig_end,    n_dig_end;
    logic [ARG_W-1:0]       r_args_left,  n_args_left;
    logic [ARG_W-1:0]       r_arg_pos,    n_arg_pos;
    logic [LENGTH_BITS-1:0] r_bytes_left, n_bytes_left;
    logic                   r_tok_open,   n_tok_open;
    logic                   r_err,        n_err;

    // Output queue
    t_result                r_q [2];
    logic                   r_wr_ptr;
    logic                   r_rd_ptr;
    logic [1:0]             r_cnt;

    logic                   adv;
    logic                   push;
    logic                   pop;

    t_result                res;
    logic                   res_valid;
    logic                   do_inline;
    logic                   do_num;
    t_phase                 num_phase;
    t_phase                 num_phase_cr;
    logic                   do_close;
    logic                   close_nul;
    logic                   fail;
    logic [2:0]             fail_code;
    logic [NUM_W+3:0]       mul10;
    logic [7:0]             b;
    logic                   is_digit;
    logic                   is_space;

    assign adv           = r_in_valid && !r_cnt[1];
    assign s_axis_tready = !r_in_valid || adv;
    assign push          = adv && res_valid;
    assign pop           = m_axis_tvalid && m_axis_tready;

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {r_q[r_rd_ptr].error_code, r_q[r_rd_ptr].arg_count,
                            r_q[r_rd_ptr].arg_index, r_q[r_rd_ptr].arg_byte};
    assign m_axis_tuser  = {r_q[r_rd_ptr].arg_null, r_q[r_rd_ptr].arg_done,
                            r_q[r_rd_ptr].byte_valid};
    assign m_axis_tlast  = r_q[r_rd_ptr].cmd_done;

    assign b        = r_in_byte;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    assign mul10    = ({4'b0, r_num} << 3) + ({4'b0, r_num} << 1)
                    + (NUM_W + 4)'(b - CH_ZERO);

    always_comb begin
        n_phase      = r_phase;
        n_num        = r_num;
        n_neg        = r_neg;
        n_dig_seen   = r_dig_seen;
        n_dig_end    = r_dig_end;
        n_args_left  = r_args_left;
        n_arg_pos    = r_arg_pos;
        n_bytes_left = r_bytes_left;
        n_tok_open   = r_tok_open;
        n_err        = r_err;
        res          = '0;
        res_valid    = 1'b0;
        do_inline    = 1'b0;
        do_num       = 1'b0;
        num_phase    = PH_COUNT;
        num_phase_cr = PH_COUNT_CR;
        do_close     = 1'b0;
        close_nul    = 1'b0;
        fail         = 1'b0;
        fail_code    = ERR_NONE;

        if (!r_err) begin
            case (r_phase)
                PH_IDLE: begin
                    n_arg_pos  = '0;
                    n_tok_open = 1'b0;
                    if (b == CH_CR) begin
                        n_phase = PH_IDLE_CR;
                    end else if (b == CH_STAR) begin
                        n_num      = '0;
                        n_neg      = 1'b0;
                        n_dig_seen = 1'b0;
                        n_dig_end  = 1'b0;
                        n_phase    = PH_COUNT;
                    end else begin
                        do_inline = 1'b1;
                    end
                end
                PH_IDLE_CR: begin
                    if (b == CH_LF) begin
                        n_phase = PH_IDLE;
                    end else begin
                        do_inline = 1'b1;
                    end
                end
                PH_INLINE: begin
                    do_inline = 1'b1;
                end
                PH_INLINE_CR: begin
                    if (b == CH_LF) begin
                        res_valid     = 1'b1;
                        res.cmd_done  = 1'b1;
                        res.arg_count = 7'(r_arg_pos);
                        n_phase       = PH_IDLE;
                        n_arg_pos     = '0;
                        n_tok_open    = 1'b0;
                    end else begin
                        do_inline = 1'b1;
                    end
                end
                PH_COUNT: begin
                    do_num = 1'b1;
                end
                PH_COUNT_CR: begin
                    if (b == CH_LF) begin
                        if (r_neg && (r_num >= NUM_W'(2))) begin
                            fail      = 1'b1;
                            fail_code = ERR_BELOW_M1;
                        end else if (r_neg && (r_num == NUM_W'(1))) begin
                            // Null array closes the command at once.
                            res_valid    = 1'b1;
                            res.arg_null = 1'b1;
                            res.cmd_done = 1'b1;
                            n_phase      = PH_IDLE;
                        end else if (r_num > ARGS_LIM) begin
                            fail      = 1'b1;
                            fail_code = ERR_MANY_ARGS;
                        end else if (r_num == '0) begin
                            res_valid    = 1'b1;
                            res.cmd_done = 1'b1;
                            n_phase      = PH_IDLE;
                        end else begin
                            n_args_left = r_num[ARG_W-1:0];
                            n_arg_pos   = '0;
                            n_phase     = PH_DOLLAR;
                        end
                    end else begin
                        n_dig_end = 1'b1;
                        do_num    = 1'b1;
                    end
                end
                PH_DOLLAR: begin
                    if (b != CH_DOLLAR) begin
                        fail      = 1'b1;
                        fail_code = ERR_NO_DOLLAR;
                    end else begin
                        n_num      = '0;
                        n_neg      = 1'b0;
                        n_dig_seen = 1'b0;
                        n_dig_end  = 1'b0;
                        n_phase    = PH_LEN;
                    end
                end
                PH_LEN: begin
                    do_num       = 1'b1;
                    num_phase    = PH_LEN;
                    num_phase_cr = PH_LEN_CR;
                end
                PH_LEN_CR: begin
                    if (b == CH_LF) begin
                        if (r_neg && (r_num >= NUM_W'(2))) begin
                            fail      = 1'b1;
                            fail_code = ERR_BELOW_M1;
                        end else if (r_neg && (r_num == NUM_W'(1))) begin
                            do_close  = 1'b1;
                            close_nul = 1'b1;
                        end else if (r_num[LENGTH_BITS]) begin
                            fail      = 1'b1;
                            fail_code = ERR_BAD_NUM;
                        end else begin
                            n_bytes_left = r_num[LENGTH_BITS-1:0];
                            n_phase      = (r_num == '0) ? PH_PAY_CR : PH_PAYLOAD;
                        end
                    end else begin
                        n_dig_end    = 1'b1;
                        do_num       = 1'b1;
                        num_phase    = PH_LEN;
                        num_phase_cr = PH_LEN_CR;
                    end
                end
                PH_PAYLOAD: begin
                    n_bytes_left   = r_bytes_left - LENGTH_BITS'(1);
                    if (n_bytes_left == '0) begin
                        n_phase = PH_PAY_CR;
                    end
                    res_valid      = 1'b1;
                    res.arg_byte   = b;
                    res.byte_valid = 1'b1;
                    res.arg_index  = r_arg_pos[5:0];
                end
                PH_PAY_CR: begin
                    if (b != CH_CR) begin
                        fail      = 1'b1;
                        fail_code = ERR_NO_CRLF;
                    end else begin
                        n_phase = PH_PAY_LF;
                    end
                end
                PH_PAY_LF: begin
                    if (b != CH_LF) begin
                        fail      = 1'b1;
                        fail_code = ERR_NO_CRLF;
                    end else begin
                        do_close = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // A byte of a count or length line other than its line feed.
        if (do_num) begin
            if (b == CH_CR) begin
                if (!n_dig_seen) begin
                    fail      = 1'b1;
                    fail_code = ERR_BAD_NUM;
                end else begin
                    n_phase = num_phase_cr;
                end
            end else begin
                n_phase = num_phase;
                if (!n_dig_end) begin
                    if (is_digit) begin
                        n_dig_seen = 1'b1;
                        if (|mul10[NUM_W+3:LENGTH_BITS]) begin
                            n_num = NUM_SAT;
                        end else begin
                            n_num = mul10[NUM_W-1:0];
                        end
                    end else if (n_dig_seen) begin
                        n_dig_end = 1'b1;
                    end else if ((b == CH_MINUS) && !n_neg) begin
                        n_neg = 1'b1;
                    end else begin
                        fail      = 1'b1;
                        fail_code = ERR_BAD_NUM;
                    end
                end
            end
        end

        if (do_close) begin
            n_arg_pos     = r_arg_pos + ARG_W'(1);
            n_args_left   = r_args_left - ARG_W'(1);
            res_valid     = 1'b1;
            res.arg_index = r_arg_pos[5:0];
            res.arg_done  = 1'b1;
            res.arg_null  = close_nul;
            if (n_args_left == '0) begin
                n_phase       = PH_IDLE;
                res.cmd_done  = 1'b1;
                res.arg_count = 7'(n_arg_pos);
            end else begin
                n_phase = PH_DOLLAR;
            end
        end

        // Inline form works on the position and token flag after any idle clear.
        if (do_inline) begin
            n_phase = (b == CH_CR) ? PH_INLINE_CR : PH_INLINE;
            if (is_space) begin
                if (n_tok_open) begin
                    res_valid     = 1'b1;
                    res.arg_index = n_arg_pos[5:0];
                    res.arg_done  = 1'b1;
                    n_tok_open    = 1'b0;
                    n_arg_pos     = n_arg_pos + ARG_W'(1);
                end
            end else if (!n_tok_open && (n_arg_pos >= ARG_W'(MAX_ARGS))) begin
                fail      = 1'b1;
                fail_code = ERR_MANY_ARGS;
            end else begin
                n_tok_open     = 1'b1;
                res_valid      = 1'b1;
                res.arg_byte   = b;
                res.byte_valid = 1'b1;
                res.arg_index  = n_arg_pos[5:0];
            end
        end

        if (fail) begin
            n_err          = 1'b1;
            res            = '0;
            res.error_code = fail_code;
            res_valid      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_phase      <= PH_IDLE;
            r_num        <= '0;
            r_neg        <= 1'b0;
            r_dig_seen   <= 1'b0;
            r_dig_end    <= 1'b0;
            r_args_left  <= '0;
            r_arg_pos    <= '0;
            r_bytes_left <= '0;
            r_tok_open   <= 1'b0;
            r_err        <= 1'b0;
            r_wr_ptr     <= 1'b0;
            r_rd_ptr     <= 1'b0;
            r_cnt        <= 2'd0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_phase      <= n_phase;
                r_num        <= n_num;
                r_neg        <= n_neg;
                r_dig_seen   <= n_dig_seen;
                r_dig_end    <= n_dig_end;
                r_args_left  <= n_args_left;
                r_arg_pos    <= n_arg_pos;
                r_bytes_left <= n_bytes_left;
                r_tok_open   <= n_tok_open;
                r_err        <= n_err;
            end
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (push) begin
            r_q[r_wr_ptr] <= res;
        end
    end

    // An error, once reported, holds until reset.
    `RRSP_ASSERT_RST(a_err_sticky, i_clk, i_rst_n, r_err |=> r_err, "error flag cleared")
    // After the error result, no further request produces a result.
    `RRSP_ASSERT_RST(a_no_push_after_err, i_clk, i_rst_n, !(r_err && push), "result after error")
    // The output queue never takes a result while both entries are occupied.
    `RRSP_ASSERT_RST(a_queue_room, i_clk, i_rst_n, !(push && r_cnt == 2'd2), "queue overflow")
    // Array form only waits for a '$' while arguments remain.
    `RRSP_ASSERT_RST(a_args_left, i_clk, i_rst_n,
        !(r_phase == PH_DOLLAR && r_args_left == '0), "no argument left in array")
    `RRSP_ASSERT_ALWAYS(a_pos_bound, i_clk, !i_rst_n || (r_arg_pos <= ARG_W'(MAX_ARGS)),
        "argument position out of range")

endmodule

`default_nettype wire
